### hdl/sdr_pkg.sv
package sdr_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Stream payload widths, padded to whole bytes
    localparam int IN_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8;

    typedef logic [DATA_WIDTH-1:0] t_word;

    // One classified operand pair, as handed from the front end to the divider
    typedef struct packed {
        t_word mag_a;     // dividend magnitude
        t_word mag_b;     // divisor magnitude
        logic  neg_q;     // negate the quotient
        logic  neg_r;     // negate the remainder
        logic  div_zero;  // divisor was zero
    } t_op;

endpackage

### hdl/sdr_front.sv
module sdr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sdr_pkg::t_word i_dividend,
    input  sdr_pkg::t_word i_divisor,
    output logic          o_valid,
    input  logic          i_ready,
    output sdr_pkg::t_op  o_op
);

    logic         r_valid;
    sdr_pkg::t_op r_op;
    sdr_pkg::t_op n_op;
    logic         w_neg_a;
    logic         w_neg_b;

    assign w_neg_a = i_dividend[sdr_pkg::DATA_WIDTH-1];
    assign w_neg_b = i_divisor[sdr_pkg::DATA_WIDTH-1];

    // Take magnitudes as unsigned words; the most negative value maps onto itself
    always_comb begin
        n_op.mag_a    = w_neg_a ? (~i_dividend + 1'b1) : i_dividend;
        n_op.mag_b    = w_neg_b ? (~i_divisor + 1'b1) : i_divisor;
        n_op.neg_q    = w_neg_a ^ w_neg_b;
        n_op.neg_r    = w_neg_a;
        n_op.div_zero = (i_divisor == '0);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_op    = r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op <= n_op;
        end
    end

endmodule

### hdl/sdr_fifo.sv
module sdr_fifo (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  sdr_pkg::t_op i_op,
    output logic         o_valid,
    input  logic         i_pop,
    output sdr_pkg::t_op o_op
);

    localparam int AW = sdr_pkg::FIFO_AW;

    sdr_pkg::t_op r_mem [sdr_pkg::FIFO_DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [AW:0]   r_count;
    logic          w_push;
    logic          w_pop;

    assign o_ready = (r_count != (AW+1)'(sdr_pkg::FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(sdr_pkg::FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(sdr_pkg::FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

### hdl/sdr_back.sv
module sdr_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_pop,
    input  sdr_pkg::t_op                        i_op,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [sdr_pkg::OUT_TDATA_W-1:0]     o_data,
    output logic                                o_div_zero
);

    localparam int W = sdr_pkg::DATA_WIDTH;

    // Stage 0 holds the loaded pair; stage k holds the result of k quotient steps
    logic           r_vld [0:W];
    sdr_pkg::t_word r_rem [0:W];
    sdr_pkg::t_word r_aq  [0:W];
    sdr_pkg::t_word r_mb  [0:W];
    logic           r_nq  [0:W];
    logic           r_nr  [0:W];
    logic           r_dz  [0:W];

    logic           r_out_valid;
    sdr_pkg::t_word r_quo;
    sdr_pkg::t_word r_rmd;
    logic           r_out_dz;
    logic           w_adv;

    // Advance the whole pipe whenever the output register is free or drains
    assign w_adv = !r_out_valid || i_ready;
    assign o_pop = w_adv && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rem[0] <= '0;
            r_aq[0]  <= i_op.mag_a;
            r_mb[0]  <= i_op.mag_b;
            r_nq[0]  <= i_op.neg_q;
            r_nr[0]  <= i_op.neg_r;
            r_dz[0]  <= i_op.div_zero;
        end
    end

    for (genvar k = 1; k <= W; k++) begin : g_step
        logic [W:0]     w_trial;
        logic [W:0]     w_diff;
        logic           w_ge;
        sdr_pkg::t_word w_rem;

        // Shift in the next dividend bit, keep the difference when it does not borrow
        assign w_trial = {r_rem[k-1], r_aq[k-1][W-1]};
        assign w_diff  = w_trial - {1'b0, r_mb[k-1]};
        assign w_ge    = !w_diff[W];
        assign w_rem   = w_ge ? w_diff[W-1:0] : w_trial[W-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_adv) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_rem[k] <= w_rem;
                r_aq[k]  <= {r_aq[k-1][W-2:0], w_ge};
                r_mb[k]  <= r_mb[k-1];
                r_nq[k]  <= r_nq[k-1];
                r_nr[k]  <= r_nr[k-1];
                r_dz[k]  <= r_dz[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_vld[W];
        end
    end

    // Apply signs: quotient by operand sign mismatch, remainder by dividend sign
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_quo    <= r_nq[W] ? (~r_aq[W] + 1'b1) : r_aq[W];
            r_rmd    <= r_nr[W] ? (~r_rem[W] + 1'b1) : r_rem[W];
            r_out_dz <= r_dz[W];
        end
    end

    assign o_valid    = r_out_valid;
    assign o_data     = sdr_pkg::OUT_TDATA_W'({r_rmd, r_quo});
    assign o_div_zero = r_out_dz;

endmodule

### hdl/signed_divide_remainder_unit.sv
// Signed divide with remainder, restoring algorithm, one quotient bit per pipeline stage.
// Throughput: one transaction per cycle unless m_axis_tready stalls the stage-per-bit pipe.
// Reset (i_rst_n low, synchronous) drops every in-flight transaction and empties the queue.
// Payload registers keep stale values across reset; valid flags and queue state clear.
module signed_divide_remainder_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Operand stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] dividend, [63:32] divisor (signed)
    input  logic [sdr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // Result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] quotient, [63:32] remainder (signed)
    output logic [sdr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] divide_by_zero
    output logic                            m_axis_tuser
);

    localparam int W = sdr_pkg::DATA_WIDTH;

    sdr_pkg::t_word w_dividend;
    sdr_pkg::t_word w_divisor;

    // Front to queue
    logic           w_fr_valid;
    logic           w_fr_ready;
    sdr_pkg::t_op   w_fr_op;

    // Queue to divider
    logic           w_q_valid;
    logic           w_q_pop;
    sdr_pkg::t_op   w_q_op;

    assign w_dividend = s_axis_tdata[W-1:0];
    assign w_divisor  = s_axis_tdata[2*W-1:W];

    // Front end: take the transaction, strip signs, flag a zero divisor
    sdr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_valid    (w_fr_valid),
        .i_ready    (w_fr_ready),
        .o_op       (w_fr_op)
    );

    // Short queue so the front keeps accepting while the divider stalls
    sdr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_valid),
        .o_ready (w_fr_ready),
        .i_op    (w_fr_op),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_op    (w_q_op)
    );

    // Back end: bit-per-stage restoring divide, sign fix-up, output register
    sdr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .o_pop      (w_q_pop),
        .i_op       (w_q_op),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata),
        .o_div_zero (m_axis_tuser)
    );

endmodule

### hdl/sdr_checker.sv
module sdr_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [sdr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [sdr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser
);

    localparam int W = sdr_pkg::DATA_WIDTH;

    logic [W-1:0] w_quo;
    logic [W-1:0] w_rmd;

    assign w_quo = m_axis_tdata[W-1:0];
    assign w_rmd = m_axis_tdata[2*W-1:W];

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Drop all results after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // Zero divisor with non-negative dividend gives quotient of minus one
    a_dz_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser && !w_rmd[W-1] |-> w_quo == '1)
        else $error("divide by zero quotient wrong for non-negative dividend");

    // Zero divisor with negative dividend gives quotient of one
    a_dz_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser && w_rmd[W-1] |-> w_quo == W'(1))
        else $error("divide by zero quotient wrong for negative dividend");

endmodule

bind signed_divide_remainder_unit sdr_checker u_sdr_checker (.*);

### tb/quotient_remainder_checker.sv
module quotient_remainder_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    // [31:0] dividend, [63:32] divisor
    input  logic [sdr_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    // [31:0] quotient, [63:32] remainder
    input  logic [sdr_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    // [0] divide_by_zero
    input  logic                            i_m_tuser,
    output int                              o_mismatch_count,
    output int                              o_pending_count,
    output int                              o_checked_count,
    output int                              o_zero_divide_count
);
    import sdr_pkg::*;

    typedef struct packed {
        t_word quotient;
        t_word remainder;
        logic  div_zero;
    } t_quotient_remainder;

    t_quotient_remainder expected_results[$];

    // Truncating signed divide on unsigned magnitudes; a zero divisor accepts
    // every quotient bit, so its magnitude is all ones and the remainder is the dividend.
    function automatic t_quotient_remainder divide_signed(input t_word dividend,
                                                          input t_word divisor);
        t_word               mag_n;
        t_word               mag_d;
        t_word               q;
        t_word               r;
        logic                neg_n;
        logic                neg_d;
        t_quotient_remainder res;
        neg_n = dividend[DATA_WIDTH-1];
        neg_d = divisor[DATA_WIDTH-1];
        mag_n = neg_n ? t_word'(-dividend) : dividend;
        mag_d = neg_d ? t_word'(-divisor) : divisor;
        if (mag_d == '0) begin
            q = '1;
            r = mag_n;
        end else begin
            q = mag_n / mag_d;
            r = mag_n % mag_d;
        end
        if (neg_n != neg_d) q = -q;
        if (neg_n) r = -r;
        res.quotient  = q;
        res.remainder = r;
        res.div_zero  = (mag_d == '0);
        return res;
    endfunction

    initial begin
        o_mismatch_count    <= 0;
        o_pending_count     <= 0;
        o_checked_count     <= 0;
        o_zero_divide_count <= 0;
    end

    always @(posedge i_clk) begin
        t_quotient_remainder want;
        t_word               got_q;
        t_word               got_r;
        if (!i_rst_n) begin
            expected_results.delete();
            o_pending_count <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                want = divide_signed(i_s_tdata[DATA_WIDTH-1:0],
                                     i_s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
                expected_results.push_back(want);
                if (want.div_zero) o_zero_divide_count <= o_zero_divide_count + 1;
            end
            if (i_m_tvalid && i_m_tready) begin
                got_q = i_m_tdata[DATA_WIDTH-1:0];
                got_r = i_m_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected: %s %h %s %h dbz %b",
                             $time, "quotient", got_q, "remainder", got_r, i_m_tuser);
                    o_mismatch_count <= o_mismatch_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got_q !== want.quotient ||
                        got_r !== want.remainder ||
                        i_m_tuser !== want.div_zero) begin
                        $display("%0t: mismatch expected q=%h r=%h dbz=%b %s q=%h r=%h dbz=%b",
                                 $time, want.quotient, want.remainder, want.div_zero,
                                 "actual", got_q, got_r, i_m_tuser);
                        o_mismatch_count <= o_mismatch_count + 1;
                    end
                    o_checked_count <= o_checked_count + 1;
                end
            end
            o_pending_count <= expected_results.size();
        end
    end

endmodule

### tb/signed_divide_remainder_unit_test.sv
module signed_divide_remainder_unit_test;
    import sdr_pkg::*;

    // Most negative and most positive words, and how long the receiver holds off
    // while the sender keeps pushing operand pairs.
    localparam t_word MOST_NEG         = t_word'(1) << (DATA_WIDTH - 1);
    localparam t_word MOST_POS         = ~MOST_NEG;
    localparam t_word MINUS_ONE        = '1;
    localparam int    LONG_HOLD_CYCLES = 300;
    localparam int    PIPE_LATENCY     = DATA_WIDTH + 3;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // [31:0] dividend, [63:32] divisor
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [31:0] quotient, [63:32] remainder
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // [0] divide_by_zero
    logic                   m_axis_tuser;

    int mismatch_count;
    int pending_count;
    int checked_count;
    int zero_divide_count;

    // Shared between stimulus and receiver: idling switch and long hold-off request
    bit idle_enable;
    bit long_hold_pending;
    int pairs_sent;

    signed_divide_remainder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    quotient_remainder_checker result_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_s_tvalid          (s_axis_tvalid),
        .i_s_tready          (s_axis_tready),
        .i_s_tdata           (s_axis_tdata),
        .i_m_tvalid          (m_axis_tvalid),
        .i_m_tready          (m_axis_tready),
        .i_m_tdata           (m_axis_tdata),
        .i_m_tuser           (m_axis_tuser),
        .o_mismatch_count    (mismatch_count),
        .o_pending_count     (pending_count),
        .o_checked_count     (checked_count),
        .o_zero_divide_count (zero_divide_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("[signed_divide_remainder_unit] ERROR");
        $finish;
    end

    // Offer one operand pair and hold it until the transaction completes.
    // Called just after a rising edge; returns at the edge that accepted it.
    task automatic send_pair(input t_word dividend, input t_word divisor);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {divisor, dividend};
        do @(posedge i_clk); while (!s_axis_tready);
        pairs_sent++;
    endtask

    // Drop valid for a random burst, but only now and then and only while idling is on
    task automatic sender_gap();
        if (idle_enable && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // Mix of operand shapes: wide random words dominate so every bit toggles,
    // small and mid-size values give non-trivial quotients, extremes hit the edges.
    function automatic t_word shaped_word();
        t_word w;
        case ($urandom_range(0, 9))
            4: w = t_word'($urandom_range(0, 31));
            5: begin
                case ($urandom_range(0, 4))
                    0: w = MOST_NEG;
                    1: w = MOST_POS;
                    2: w = '0;
                    3: w = MINUS_ONE;
                    default: w = t_word'(1);
                endcase
            end
            6: w = t_word'(1) << $urandom_range(0, DATA_WIDTH - 1);
            7: w = t_word'($urandom_range(0, 65535));
            default: w = t_word'($urandom());
        endcase
        if ($urandom_range(0, 1) == 1 && $urandom_range(0, 9) inside {[4:7]}) w = -w;
        return w;
    endfunction

    task automatic send_random_pair();
        t_word dividend;
        t_word divisor;
        dividend = shaped_word();
        divisor  = ($urandom_range(0, 24) == 0) ? t_word'(0) : shaped_word();
        sender_gap();
        send_pair(dividend, divisor);
    endtask

    // Hold until every expected result has been checked
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    // Receiver: random stall bursts, a long hold-off on request, full speed otherwise
    initial begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_pending) begin
                long_hold_pending = 1'b0;
                stall_left        = LONG_HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 9) == 0) begin
                stall_left    = $urandom_range(1, 12) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int failures;
        idle_enable       = 1'b1;
        long_hold_pending = 1'b0;
        pairs_sent        = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Corner pairs: signs, truncation, the most negative dividend, overflow,
        // and division by zero for each dividend sign.
        sender_gap(); send_pair(t_word'(0), t_word'(1));
        sender_gap(); send_pair(t_word'(1), t_word'(1));
        sender_gap(); send_pair(MINUS_ONE, t_word'(1));
        sender_gap(); send_pair(t_word'(7), t_word'(2));
        sender_gap(); send_pair(-t_word'(7), t_word'(2));
        sender_gap(); send_pair(t_word'(7), -t_word'(2));
        sender_gap(); send_pair(-t_word'(7), -t_word'(2));
        sender_gap(); send_pair(t_word'(3), t_word'(7));
        sender_gap(); send_pair(MOST_NEG, MINUS_ONE);
        sender_gap(); send_pair(MOST_NEG, t_word'(1));
        sender_gap(); send_pair(MOST_NEG, t_word'(2));
        sender_gap(); send_pair(MOST_NEG, MOST_NEG);
        sender_gap(); send_pair(MOST_NEG, MOST_POS);
        sender_gap(); send_pair(MOST_POS, MOST_NEG);
        sender_gap(); send_pair(MOST_POS, t_word'(1));
        sender_gap(); send_pair(MOST_POS, MINUS_ONE);
        sender_gap(); send_pair(MINUS_ONE, MOST_NEG);
        sender_gap(); send_pair(t_word'(123456789), t_word'(1000));
        sender_gap(); send_pair(t_word'(5), t_word'(0));
        sender_gap(); send_pair(-t_word'(5), t_word'(0));
        sender_gap(); send_pair(t_word'(0), t_word'(0));
        sender_gap(); send_pair(MOST_NEG, t_word'(0));
        sender_gap(); send_pair(MOST_POS, t_word'(0));
        sender_gap(); send_pair(MINUS_ONE, t_word'(0));

        repeat (300) send_random_pair();

        // Stall the result side for a long stretch and keep pushing operand pairs,
        // so the pipe and the operand queue fill and input ready drops.
        long_hold_pending = 1'b1;
        repeat (80) send_random_pair();

        // Pause the sender until everything in flight has come out
        s_axis_tvalid <= 1'b0;
        wait_drained();

        repeat (300) send_random_pair();

        // Closing stretch at full rate on both sides
        idle_enable = 1'b0;
        repeat (120) send_random_pair();
        s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (PIPE_LATENCY + 10) @(posedge i_clk);

        failures = mismatch_count;
        if (pending_count != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_count);
            failures += pending_count;
        end
        $display("Run covered %0d operand pairs: corner pairs, shaped random operands,",
                 pairs_sent);
        $display("a %0d-cycle output hold-off, %0d results checked, %0d divides by zero",
                 LONG_HOLD_CYCLES, checked_count, zero_divide_count);
        if (failures == 0) begin
            $display("[signed_divide_remainder_unit] OK");
        end else begin
            $display("[signed_divide_remainder_unit] ERROR");
        end
        $finish;
    end

endmodule
